// ----- rtl/core/vpps_pkg.sv -----
package vpps_pkg;

   localparam int CNT_W = 7;   // tick index and count width
   localparam int LVL_W = 8;   // pump level width

   localparam logic [LVL_W-1:0] LEVEL_MIN_RST = 8'd0;
   localparam logic [LVL_W-1:0] LEVEL_MAX_RST = 8'd99;

   // request op codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // register indexes (byte address bit 2)
   localparam logic REG_LEVEL_MIN = 1'b0;
   localparam logic REG_LEVEL_MAX = 1'b1;

   // level mapper status toward the top level
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] on;
   } staged_type;

endpackage

// ----- rtl/core/vpps_div.sv -----
module vpps_div #(
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [DW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          fits;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/vpps_ctrl.sv -----
module vpps_ctrl #(
   parameter int MAX_PERIOD = 100,
   parameter int DW         = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [vpps_pkg::LVL_W-1:0] level,
   input  logic [vpps_pkg::LVL_W-1:0] level_min,
   input  logic [vpps_pkg::LVL_W-1:0] level_max,
   output vpps_pkg::staged_type      status,
   output logic                      div_start,
   output logic [DW-1:0]             div_dividend,
   output logic [DW-1:0]             div_divisor,
   input  logic                      div_done,
   input  logic [DW-1:0]             div_quotient,
   input  logic [DW-1:0]             div_remainder
);

   import vpps_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAP  = 3'd1;   // waiting on mapping divide
   localparam logic [2:0] ST_GCD  = 3'd2;   // Euclid check / launch
   localparam logic [2:0] ST_MOD  = 3'd3;   // waiting on a % b
   localparam logic [2:0] ST_PER  = 3'd4;   // waiting on MAX_PERIOD / g
   localparam logic [2:0] ST_ON   = 3'd5;   // waiting on raw / g

   localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_PERIOD);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] raw_ff, raw_in;
   logic [CNT_W-1:0] period_ff, period_in;

   logic [LVL_W-1:0] lv;
   logic [LVL_W-1:0] num;
   logic [LVL_W-1:0] span;
   logic             has_range;

   // clamp and map operands, valid in the start cycle
   always_comb begin
      if (level < level_min)      lv = level_min;
      else if (level > level_max) lv = level_max;
      else                        lv = level;
      has_range = level_max > level_min;
      num       = lv - level_min;
      span      = level_max - level_min;
   end

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      raw_in       = raw_ff;
      period_in    = period_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (has_range) begin
                  // round half up: (2*num*MAXP + range) / (2*range)
                  div_start    = 1'b1;
                  div_dividend = DW'(num) * DW'(2 * MAX_PERIOD) + DW'(span);
                  div_divisor  = DW'({span, 1'b0});
                  state_in     = ST_MAP;
               end else begin
                  raw_in   = '0;
                  a_in     = '0;
                  b_in     = MAXP;
                  state_in = ST_GCD;
               end
            end
         end
         ST_MAP: begin
            if (div_done) begin
               raw_in   = div_quotient[CNT_W-1:0];
               a_in     = div_quotient[CNT_W-1:0];
               b_in     = MAXP;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            div_start = 1'b1;
            if (b_ff != '0) begin
               div_dividend = DW'(a_ff);
               div_divisor  = DW'(b_ff);
               state_in     = ST_MOD;
            end else begin
               // a holds the gcd
               div_dividend = DW'(MAXP);
               div_divisor  = DW'(a_ff);
               state_in     = ST_PER;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               a_in     = b_ff;
               b_in     = div_remainder[CNT_W-1:0];
               state_in = ST_GCD;
            end
         end
         ST_PER: begin
            if (div_done) begin
               period_in    = div_quotient[CNT_W-1:0];
               div_start    = 1'b1;
               div_dividend = DW'(raw_ff);
               div_divisor  = DW'(a_ff);
               state_in     = ST_ON;
            end
         end
         ST_ON: begin
            if (div_done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      raw_ff    <= raw_in;
      period_ff <= period_in;
   end

   assign status.busy   = state_ff != ST_IDLE;
   assign status.done   = (state_ff == ST_ON) && div_done;
   assign status.period = period_ff;
   assign status.on     = div_quotient[CNT_W-1:0];

endmodule

// ----- rtl/core/variable_period_pulse_skip.sv -----
// Channel   Direction  Ports                                   Moves
// req       in         req_valid/ready, req_op, req_level      tick or set-level item
// rsp       out        rsp_valid/ready, rsp_pump_on,           one result per item
//                      rsp_period_end
// csr       in/out     psel/penable/pwrite/paddr/pwdata,       level_min, level_max
//                      prdata, pready
//
// A tick is done in the accept cycle; its result lands in the output register.
// A set-level item answers at once, then the shared divider runs the mapping
// divide (skipped for an empty or inverted range), Euclid (up to about ten
// a % b steps, each with its own launch state) and two quotient divides; no
// new item is taken meanwhile.
// Synchronous active-high reset; no clearing pass. req_ready also drops while
// a result waits and rsp_ready is low.
module variable_period_pulse_skip #(
   parameter int MAX_PERIOD = 100
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [vpps_pkg::LVL_W-1:0] req_level,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pump_on,
   output logic                       rsp_period_end,
   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   import vpps_pkg::*;

   // widest mapping numerator: 2*255*MAX_PERIOD + 255
   localparam int DIV_W = $clog2(2 * 255 * MAX_PERIOD + 256);
   localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_PERIOD);

   // config registers
   logic [LVL_W-1:0] level_min_ff, level_min_in;
   logic [LVL_W-1:0] level_max_ff, level_max_in;

   // period state
   logic [CNT_W-1:0] tick_index_ff, tick_index_in;
   logic [CNT_W-1:0] cur_period_ff, cur_period_in;
   logic [CNT_W-1:0] cur_on_ff, cur_on_in;
   logic [CNT_W-1:0] staged_period_ff, staged_period_in;
   logic [CNT_W-1:0] staged_on_ff, staged_on_in;
   logic             drive_ff, drive_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pump_on_ff, rsp_pump_on_in;
   logic             rsp_period_end_ff, rsp_period_end_in;

   logic             accept;
   logic             csr_write;
   logic             drive_tick;
   logic [CNT_W-1:0] index_next;
   logic             wrap;

   staged_type       sts;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;
   logic [DIV_W-1:0] div_remainder;

   // take a new item only when the mapper is idle and the output slot frees up
   assign req_ready = !sts.busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // register writes
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      level_min_in = level_min_ff;
      level_max_in = level_max_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_LEVEL_MIN: level_min_in = pwdata[LVL_W-1:0];
            REG_LEVEL_MAX: level_max_in = pwdata[LVL_W-1:0];
            default:       level_min_in = level_min_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LEVEL_MIN: prdata = {{(32-LVL_W){1'b0}}, level_min_ff};
         REG_LEVEL_MAX: prdata = {{(32-LVL_W){1'b0}}, level_max_ff};
         default:       prdata = '0;
      endcase
   end

   // zero-cross tick: drive from the index, then advance and maybe wrap
   always_comb begin
      drive_tick = drive_ff;
      if (tick_index_ff < MAXP) drive_tick = tick_index_ff < cur_on_ff;
      index_next = tick_index_ff + CNT_W'(1);
      wrap       = index_next >= cur_period_ff;
   end

   always_comb begin
      tick_index_in     = tick_index_ff;
      cur_period_in     = cur_period_ff;
      cur_on_in         = cur_on_ff;
      staged_period_in  = staged_period_ff;
      staged_on_in      = staged_on_ff;
      drive_in          = drive_ff;
      rsp_pump_on_in    = rsp_pump_on_ff;
      rsp_period_end_in = rsp_period_end_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;

      // new counts from the mapper; never in the same cycle as a tick
      if (sts.done) begin
         staged_period_in = sts.period;
         staged_on_in     = sts.on;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_op == OP_TICK) begin
            drive_in          = drive_tick;
            rsp_pump_on_in    = drive_tick;
            rsp_period_end_in = wrap;
            if (wrap) begin
               tick_index_in = '0;
               cur_period_in = staged_period_ff;
               cur_on_in     = staged_on_ff;
            end else begin
               tick_index_in = index_next;
            end
         end else begin
            // set-level: output unchanged, counts staged later
            rsp_pump_on_in    = drive_ff;
            rsp_period_end_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_min_ff     <= LEVEL_MIN_RST;
         level_max_ff     <= LEVEL_MAX_RST;
         tick_index_ff    <= '0;
         cur_period_ff    <= '0;
         cur_on_ff        <= '0;
         staged_period_ff <= '0;
         staged_on_ff     <= '0;
         drive_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         level_min_ff     <= level_min_in;
         level_max_ff     <= level_max_in;
         tick_index_ff    <= tick_index_in;
         cur_period_ff    <= cur_period_in;
         cur_on_ff        <= cur_on_in;
         staged_period_ff <= staged_period_in;
         staged_on_ff     <= staged_on_in;
         drive_ff         <= drive_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_pump_on_ff    <= rsp_pump_on_in;
      rsp_period_end_ff <= rsp_period_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pump_on    = rsp_pump_on_ff;
   assign rsp_period_end = rsp_period_end_ff;

   // level mapper sequencer
   vpps_ctrl #(
      .MAX_PERIOD (MAX_PERIOD),
      .DW         (DIV_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (accept && (req_op == OP_SET)),
      .level         (req_level),
      .level_min     (level_min_ff),
      .level_max     (level_max_ff),
      .status        (sts),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_done      (div_done),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder)
   );

   // shared bit-serial divider
   vpps_div #(
      .DW (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import vpps_pkg::*;

   localparam int PULSE_PERIOD  = 100;   // MAX_PERIOD of the block
   localparam int SETTLE_CYCLES = 300;   // lets a set-level item finish on the divider
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off (pressure)
   localparam int PHASE_ITEMS   = 141;   // random items per config phase
   localparam int NUM_PHASES    = 8;

   typedef struct packed {
      logic pump_on;
      logic period_end;
   } pump_result_type;

   // directed stimulus row; known = 1 means the expected result is typed in
   typedef struct packed {
      logic             op;
      logic [LVL_W-1:0] level;
      logic             known;
      logic             pump_on;
      logic             period_end;
   } pump_row_type;

   // ---------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_op;
   logic [LVL_W-1:0] req_level;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_pump_on;
   logic             rsp_period_end;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   // typed expectation travelling with the payload (directed rows only)
   logic req_known;
   logic req_known_pump;
   logic req_known_end;

   // ---------------------------------------------------------------------
   // Pulse-skip predictor state
   // ---------------------------------------------------------------------
   logic [LVL_W-1:0] cfg_lo = LEVEL_MIN_RST;
   logic [LVL_W-1:0] cfg_hi = LEVEL_MAX_RST;
   logic [CNT_W-1:0] idx_now     = '0;
   logic [CNT_W-1:0] period_now  = '0;
   logic [CNT_W-1:0] on_now      = '0;
   logic [CNT_W-1:0] period_next = '0;
   logic [CNT_W-1:0] on_next     = '0;
   logic             out_level   = 1'b0;

   pump_result_type pump_expect_q[$];
   int           fail_count    = 0;
   int           quiet_cycles  = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   bit           hold_go       = 0;
   int           hold_left     = 0;

   // Directed part, default config (0..99):
   //   after reset the running period is zero, so ticks drive low and wrap at once;
   //   full level stages a 1/1 period, zero level a 1/0 period, level above max clamps;
   //   mid level gives a 100/51 period; the rest runs against the predictor.
   pump_row_type pump_rows [0:23] = '{
      '{OP_TICK, 8'd0,   1'b1, 1'b0, 1'b1},
      '{OP_TICK, 8'd255, 1'b1, 1'b0, 1'b1},
      '{OP_SET,  8'd99,  1'b1, 1'b0, 1'b0},
      '{OP_TICK, 8'd0,   1'b1, 1'b0, 1'b1},
      '{OP_TICK, 8'd0,   1'b1, 1'b1, 1'b1},
      '{OP_SET,  8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_TICK, 8'd0,   1'b1, 1'b1, 1'b1},
      '{OP_TICK, 8'd0,   1'b1, 1'b0, 1'b1},
      '{OP_SET,  8'd255, 1'b1, 1'b0, 1'b0},
      '{OP_TICK, 8'd0,   1'b1, 1'b0, 1'b1},
      '{OP_TICK, 8'd0,   1'b1, 1'b1, 1'b1},
      '{OP_SET,  8'd50,  1'b1, 1'b1, 1'b0},
      '{OP_TICK, 8'd0,   1'b1, 1'b1, 1'b1},
      '{OP_TICK, 8'd0,   1'b1, 1'b1, 1'b0},
      '{OP_SET,  8'd25,  1'b0, 1'b0, 1'b0},
      '{OP_TICK, 8'd170, 1'b0, 1'b0, 1'b0},
      '{OP_TICK, 8'd85,  1'b0, 1'b0, 1'b0},
      '{OP_SET,  8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_TICK, 8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_SET,  8'd100, 1'b0, 1'b0, 1'b0},
      '{OP_TICK, 8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_SET,  8'd98,  1'b0, 1'b0, 1'b0},
      '{OP_TICK, 8'd0,   1'b0, 1'b0, 1'b0},
      '{OP_TICK, 8'd0,   1'b0, 1'b0, 1'b0}
   };

   variable_period_pulse_skip #(
      .MAX_PERIOD(PULSE_PERIOD)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_level      (req_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pump_on    (rsp_pump_on),
      .rsp_period_end (rsp_period_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // ---------------------------------------------------------------------
   // Clock and reset (reset applied once)
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: one item in, one result out.
   // Set-level: clamp, map to 0..PULSE_PERIOD with halves rounded up, reduce
   // raw:PULSE_PERIOD by gcd, stage. Tick: drive from current on count, advance
   // index, wrap and load staged counts at end of period.
   // ---------------------------------------------------------------------
   function automatic pump_result_type advance_pump(input logic op,
                                                    input logic [LVL_W-1:0] level);
      pump_result_type res;
      int lo, hi, lv, span, raw, a, b, t;
      res.period_end = 1'b0;
      if (op == OP_SET) begin
         lo   = cfg_lo;
         hi   = cfg_hi;
         lv   = level;
         span = hi - lo;
         raw  = 0;
         if (lv < lo) begin
            lv = lo;
         end else if (lv > hi) begin
            lv = hi;
         end
         // empty or inverted range leaves raw at zero
         if (span > 0) begin
            raw = (2 * (lv - lo) * PULSE_PERIOD + span) / (2 * span);
         end
         a = raw;
         b = PULSE_PERIOD;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         // zero raw: gcd is the full period, so 1 period count, 0 on count
         period_next = CNT_W'(PULSE_PERIOD / a);
         on_next     = CNT_W'(raw / a);
      end else begin
         if (idx_now < PULSE_PERIOD) begin
            out_level = (idx_now < on_now);
         end
         idx_now = idx_now + 1'b1;
         // period of zero right after reset wraps on the first tick
         if (idx_now >= period_now) begin
            idx_now        = '0;
            period_now     = period_next;
            on_now         = on_next;
            res.period_end = 1'b1;
         end
      end
      res.pump_on = out_level;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: config shadow, expectation push on req transfer, compare on rsp
   // transfer. Everything sampled at the rising edge (pre-NBA values).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pump_result_type predicted;
      pump_result_type want;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_LEVEL_MIN) begin
               cfg_lo = pwdata[LVL_W-1:0];
            end else begin
               cfg_hi = pwdata[LVL_W-1:0];
            end
         end
         if (req_valid && req_ready) begin
            predicted = advance_pump(req_op, req_level);
            if (req_known) begin
               pump_expect_q.push_back('{req_known_pump, req_known_end});
            end else begin
               pump_expect_q.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pump_expect_q.size() == 0) begin
               $error("unexpected transfer: pump_on=%0d period_end=%0d",
                      rsp_pump_on, rsp_period_end);
               fail_count++;
            end else begin
               want = pump_expect_q.pop_front();
               if (rsp_pump_on !== want.pump_on) begin
                  $error("pump_on: expected %0d, got %0d", want.pump_on, rsp_pump_on);
                  fail_count++;
               end
               if (rsp_period_end !== want.period_end) begin
                  $error("period_end: expected %0d, got %0d",
                         want.period_end, rsp_period_end);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles with no transfer on any port
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("** variable_period_pulse_skip: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request so the result
   // register fills and req_ready drops while the sender keeps offering.
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: optional idle gap, then hold valid and payload until transfer.
   // ---------------------------------------------------------------------
   task automatic offer_item(input logic op, input logic [LVL_W-1:0] lvl,
                             input logic known, input logic kpump, input logic kend);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_level <= LVL_W'($urandom_range(255));
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_level      <= lvl;
      req_known      <= known;
      req_known_pump <= kpump;
      req_known_end  <= kend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for all results, then let the divider finish before touching config
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pump_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write (setup + access), then read back and compare
   task automatic write_level_reg(input logic idx, input logic [LVL_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pwdata  <= '0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[LVL_W-1:0] !== val) begin
         $error("prdata: expected %0d, got %0d", val, prdata[LVL_W-1:0]);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [LVL_W-1:0] lo, hi, lvl;
      int               run_len;
      int               left;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_TICK;
      req_level      <= '0;
      req_known      <= 1'b0;
      req_known_pump <= 1'b0;
      req_known_end  <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset config, no idling
      foreach (pump_rows[i]) begin
         offer_item(pump_rows[i].op, pump_rows[i].level, pump_rows[i].known,
                    pump_rows[i].pump_on, pump_rows[i].period_end);
      end

      // config phases: default, wide, inverted, empty, narrow, mid, then random
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_and_settle();
         case (ph)
            0: begin lo = 8'd0;   hi = 8'd99;  end
            1: begin lo = 8'd0;   hi = 8'd255; end
            2: begin lo = 8'd255; hi = 8'd0;   end
            3: begin lo = 8'd77;  hi = 8'd77;  end
            4: begin lo = 8'd0;   hi = 8'd1;   end
            5: begin lo = 8'd10;  hi = 8'd200; end
            default: begin
               lo = LVL_W'($urandom_range(255));
               hi = LVL_W'($urandom_range(255));
            end
         endcase
         write_level_reg(REG_LEVEL_MIN, lo);
         write_level_reg(REG_LEVEL_MAX, hi);

         // idling mix rotates: none, sender 46, receiver 46, both 21
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         if (ph == 0) begin
            hold_go = 1;
         end

         // bursts: one set-level item with random or boundary level, then a run
         // of ticks; occasional long runs so 100-count periods wrap
         left = PHASE_ITEMS;
         while (left > 0) begin
            case ($urandom_range(7))
               0: lvl = lo;
               1: lvl = hi;
               2: lvl = lo - 1'b1;
               3: lvl = hi + 1'b1;
               4: lvl = $urandom_range(1) ? 8'd255 : 8'd0;
               default: lvl = LVL_W'($urandom_range(255));
            endcase
            offer_item(OP_SET, lvl, 1'b0, 1'b0, 1'b0);
            left--;
            run_len = ($urandom_range(5) == 0) ? $urandom_range(60, 210)
                                                : $urandom_range(0, 24);
            while (run_len > 0 && left > 0) begin
               offer_item(OP_TICK, LVL_W'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
               run_len--;
               left--;
            end
         end
      end

      drain_and_settle();
      if (fail_count == 0) begin
         $display("** variable_period_pulse_skip: PASSED **");
      end else begin
         $display("** variable_period_pulse_skip: FAILED **");
      end
      $finish;
   end

endmodule

// ----- variable_period_pulse_skip.f -----
rtl/core/vpps_pkg.sv
rtl/core/vpps_div.sv
rtl/core/vpps_ctrl.sv
rtl/core/variable_period_pulse_skip.sv
tb/sv/testbench.sv
